FILE: rtl/core/bud_pkg.sv
// package for the buddy allocator: widths, codes, states and defaults
`timescale 1ns / 1ps

package bud_pkg;

    localparam int MIN_LOG2_DEF     = 3;
    localparam int MAX_LOG2_DEF     = 16;
    localparam int HEADER_BYTES_DEF = 4;
    localparam int LINK_BYTES_DEF   = 8;

    localparam int CFG_W  = 17;
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 16;
    localparam int STAT_W = 2;
    localparam int HW_W   = 17;

    localparam logic [CFG_W-1:0] MAPPED_RESET = 17'd65536;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BIG    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_ALOOP,
        S_APOP,
        S_ACHK,
        S_ATOUCH,
        S_ASPL,
        S_ASPL2,
        S_FLOOP,
        S_FCHK,
        S_FUP,
        S_FHEAD,
        S_GTEST,
        S_GBIT,
        S_GA1,
        S_GB1,
        S_PT1,
        S_PT2,
        S_PH1,
        S_PH2,
        S_RM1,
        S_RM2,
        S_PP1,
        S_PP2,
        S_FL1,
        S_FL2,
        S_FAIL,
        S_FIN
    } t_state;

endpackage

FILE: rtl/core/bud_ram.sv
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps

module bud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/buddy_allocator_top.sv
// top level of the binary buddy allocator: sequencer over split-bit and link memories
`timescale 1ns / 1ps

// Binary buddy allocator over a heap of 2^MAX_LOG2 bytes, smallest block 2^MIN_LOG2 bytes.
// Each word on the input channel is one allocate or free request and gives exactly one
// result word. Split bits and the free-list links live in three synchronous memories of
// 2^(MAX_LOG2-MIN_LOG2) entries; the per-level list heads and tails are flip-flops. After
// reset the block sweeps every entry of the memories and takes no request meanwhile. A
// request then runs through a sequencer that does one memory step per cycle, but holds
// its result while the output register is full and stalled. A free runs longer for each
// level that it merges and ends early when it is ignored; an allocation runs longer for
// each level searched, grown and split. The registered read of the memories sets the
// step time. A finished result sits in an output register, and the next request is
// taken while it waits. mapped_bytes is written through i_cfg_we.

module buddy_allocator_top #(
    parameter int MIN_LOG2     = bud_pkg::MIN_LOG2_DEF,
    parameter int MAX_LOG2     = bud_pkg::MAX_LOG2_DEF,
    parameter int HEADER_BYTES = bud_pkg::HEADER_BYTES_DEF,
    parameter int LINK_BYTES   = bud_pkg::LINK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bud_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [bud_pkg::SIZE_W-1:0]  i_size,
    input  logic [bud_pkg::OFF_W-1:0]   i_offset,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bud_pkg::STAT_W-1:0]  o_status,
    output logic [bud_pkg::OFF_W-1:0]   o_result_offset,
    output logic [bud_pkg::HW_W-1:0]    o_high_water
);
    import bud_pkg::*;

    localparam int NB_W = MAX_LOG2 - MIN_LOG2;
    localparam int NBLK = 1 << NB_W;
    localparam int LK_W = NB_W + 1;
    localparam int NLEV = NB_W + 1;
    localparam int LV_W = $clog2(NLEV);
    localparam int ND_W = NLEV;
    localparam int AW   = (MAX_LOG2 + 2 > 18) ? MAX_LOG2 + 2 : 18;
    localparam logic [LK_W-1:0] NIL = LK_W'(NBLK);

    function automatic logic [ND_W-1:0] node_of(logic [NB_W-1:0] kb, logic [LV_W-1:0] lv);
        node_of = ND_W'(kb >> (NB_W - lv)) + ((ND_W'(1) << lv) - ND_W'(1));
    endfunction

    function automatic logic [NB_W-1:0] no_blk(logic [ND_W-1:0] n, logic [LV_W-1:0] lv);
        logic [ND_W:0] t;
        t = {1'b0, n} + (ND_W+1)'(1) - ((ND_W+1)'(1) << lv);
        no_blk = NB_W'(t << (NB_W - lv));
    endfunction

    function automatic logic [NB_W-1:0] pidx(logic [ND_W-1:0] n);
        logic [ND_W-1:0] m;
        m = n - ND_W'(1);
        pidx = NB_W'(m >> 1);
    endfunction

    function automatic logic [LV_W-1:0] lvl_for(logic [AW-1:0] req);
        logic [LV_W-1:0] lv;
        logic            hit;
        lv  = '0;
        hit = 1'b0;
        for (int k = 0; k <= NB_W; k++) begin
            if (!hit && ((AW'(1) << (MIN_LOG2 + k)) >= req)) begin
                hit = 1'b1;
                lv  = LV_W'(NB_W - k);
            end
        end
        lvl_for = lv;
    endfunction

    t_state r_state, n_state, r_ret, r_gret;

    logic [LK_W-1:0]   r_head [NLEV];
    logic [LK_W-1:0]   r_tail [NLEV];
    logic [NB_W-1:0]   r_clr;
    logic              r_kind;
    logic [SIZE_W-1:0] r_size;
    logic [OFF_W-1:0]  r_offset;
    logic [LV_W-1:0]   r_orig, r_b, r_lim, r_gl, r_sl;
    logic [NB_W-1:0]   r_sk, r_fi;
    logic [LK_W-1:0]   r_k, r_t;
    logic [ND_W-1:0]   r_node;
    logic [AW-1:0]     r_off;
    logic              r_fbit, r_second;
    logic [HW_W-1:0]   r_hwm;
    logic [CFG_W-1:0]  r_map;
    logic [STAT_W-1:0] r_status, r_ostatus;
    logic [OFF_W-1:0]  r_res, r_ores;
    logic [HW_W-1:0]   r_ohw;
    logic              r_ovalid;

    logic            sb_we, ln_we, lp_we;
    logic [NB_W-1:0] sb_wa, ln_wa, lp_wa, sb_ra, ln_ra, lp_ra;
    logic [0:0]      sb_wd, sb_rd;
    logic [LK_W-1:0] ln_wd, lp_wd, ln_rd, lp_rd;

    logic [LK_W-1:0] tl, hd;
    logic [ND_W-1:0] root_n, rootp_n, bud_n, spl_n, a_node;
    logic [AW-1:0]   right, a_off, a_need0, a_need, tend, d_req, d_dif;
    logic [NB_W-1:0] rk, d_kb;
    logic [LV_W-1:0] d_lv;
    logic            t_big, t_ok, d_big, out_free;

    assign tl      = r_tail[r_sl];
    assign hd      = r_head[r_sl];
    assign root_n  = (ND_W'(1) << r_lim) - ND_W'(1);
    assign rootp_n = (ND_W'(1) << (r_lim - LV_W'(1))) - ND_W'(1);
    assign right   = AW'(1) << (MAX_LOG2 - r_lim);
    assign rk      = NB_W'(right >> MIN_LOG2);
    assign a_off   = AW'(r_k[NB_W-1:0]) << MIN_LOG2;
    assign a_need0 = AW'(1) << (MAX_LOG2 - r_b);
    assign a_need  = (r_b < r_orig) ? (a_need0 >> 1) + AW'(LINK_BYTES) : a_need0;
    assign tend    = (r_state == S_GBIT) ? right + AW'(LINK_BYTES) : a_off + a_need;
    assign t_big   = tend > AW'(r_hwm);
    assign t_ok    = !t_big || (tend < AW'(r_map));
    assign a_node  = node_of(r_k[NB_W-1:0], r_b);
    assign spl_n   = {r_node[ND_W-2:0], 1'b1};
    assign bud_n   = ((r_node - ND_W'(1)) ^ ND_W'(1)) + ND_W'(1);
    assign d_req   = AW'(r_size) + AW'(HEADER_BYTES);
    assign d_big   = d_req > (AW'(1) << MAX_LOG2);
    assign d_lv    = lvl_for(d_req);
    assign d_dif   = AW'(r_offset) - AW'(HEADER_BYTES);
    assign d_kb    = d_dif[MAX_LOG2-1:MIN_LOG2];
    assign out_free = !r_ovalid || !i_out_stall;

    bud_ram #(.WIDTH(1), .DEPTH(NBLK)) u_split (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(sb_wa), .i_wdata(sb_wd),
        .i_raddr(sb_ra), .o_rdata(sb_rd)
    );

    bud_ram #(.WIDTH(LK_W), .DEPTH(NBLK)) u_next (
        .i_clk(i_clk), .i_we(ln_we), .i_waddr(ln_wa), .i_wdata(ln_wd),
        .i_raddr(ln_ra), .o_rdata(ln_rd)
    );

    bud_ram #(.WIDTH(LK_W), .DEPTH(NBLK)) u_prev (
        .i_clk(i_clk), .i_we(lp_we), .i_waddr(lp_wa), .i_wdata(lp_wd),
        .i_raddr(lp_ra), .o_rdata(lp_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (d_big) n_state = S_FIN;
                else if (r_kind == KIND_ALLOC) n_state = S_ALOOP;
                else if (d_lv < r_lim) n_state = S_FIN;
                else n_state = S_FLOOP;
            end
            S_ALOOP:  n_state = S_GTEST;
            S_APOP:   n_state = S_PP1;
            S_ACHK: begin
                if (!r_k[NB_W]) n_state = S_ATOUCH;
                else if (r_second) n_state = S_FAIL;
                else if (r_b != r_lim || r_b == '0) begin
                    n_state = (r_b == '0) ? S_FAIL : S_ALOOP;
                end else n_state = S_GTEST;
            end
            S_ATOUCH: begin
                if (!t_ok) n_state = S_PT1;
                else if (a_node != '0) n_state = S_FL1;
                else n_state = S_ASPL;
            end
            S_ASPL:   n_state = (r_b < r_orig) ? S_FL1 : S_FIN;
            S_ASPL2:  n_state = S_PT1;
            S_FLOOP:  n_state = (r_node == '0) ? S_FHEAD : S_FL1;
            S_FCHK:   n_state = (r_fbit || r_b == r_lim) ? S_FHEAD : S_RM1;
            S_FUP:    n_state = S_FLOOP;
            S_FHEAD:  n_state = S_PH1;
            S_GTEST:  n_state = (r_gl < r_lim) ? S_GBIT : r_gret;
            S_GBIT: begin
                if (!sb_rd[0]) n_state = S_RM1;
                else if (!t_ok) n_state = S_FAIL;
                else n_state = S_PT1;
            end
            S_GA1:    n_state = S_PT1;
            S_GB1:    n_state = (r_lim != LV_W'(1)) ? S_FL1 : S_GTEST;
            S_PT1:    n_state = S_PT2;
            S_PH1:    n_state = S_PH2;
            S_RM1:    n_state = S_RM2;
            S_PP1:    n_state = tl[NB_W] ? r_ret : S_PP2;
            S_FL1:    n_state = S_FL2;
            S_PT2, S_PH2, S_RM2, S_PP2, S_FL2: n_state = r_ret;
            S_FAIL:   n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory ports
    always_comb begin
        sb_we = 1'b0;
        ln_we = 1'b0;
        lp_we = 1'b0;
        sb_wa = r_fi;
        sb_wd = ~sb_rd;
        ln_wa = r_sk;
        ln_wd = NIL;
        lp_wa = r_sk;
        lp_wd = NIL;
        sb_ra = r_fi;
        ln_ra = r_sk;
        lp_ra = r_sk;
        case (r_state)
            S_CLR: begin
                sb_we = 1'b1;
                sb_wa = r_clr;
                sb_wd = 1'b0;
                ln_we = 1'b1;
                ln_wa = r_clr;
                lp_we = 1'b1;
                lp_wa = r_clr;
            end
            S_GTEST: sb_ra = pidx(root_n);
            S_FL2:   sb_we = 1'b1;
            S_PT1: begin
                lp_we = 1'b1;
                lp_wd = tl;
                ln_we = 1'b1;
            end
            S_PT2: begin
                ln_we = !r_t[NB_W];
                ln_wa = r_t[NB_W-1:0];
                ln_wd = {1'b0, r_sk};
            end
            S_PH1: begin
                ln_we = 1'b1;
                ln_wd = hd;
                lp_we = 1'b1;
            end
            S_PH2: begin
                lp_we = !r_t[NB_W];
                lp_wa = r_t[NB_W-1:0];
                lp_wd = {1'b0, r_sk};
            end
            S_RM2: begin
                ln_we = !lp_rd[NB_W];
                ln_wa = lp_rd[NB_W-1:0];
                ln_wd = ln_rd;
                lp_we = !ln_rd[NB_W];
                lp_wa = ln_rd[NB_W-1:0];
                lp_wd = lp_rd;
            end
            S_PP1:   lp_ra = tl[NB_W-1:0];
            S_PP2: begin
                ln_we = !lp_rd[NB_W];
                ln_wa = lp_rd[NB_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_gret   <= S_IDLE;
            r_clr    <= '0;
            r_lim    <= LV_W'(NLEV - 1);
            r_hwm    <= HW_W'(LINK_BYTES);
            r_map    <= MAPPED_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NLEV; i++) begin
                r_head[i] <= (i == NLEV - 1) ? '0 : NIL;
                r_tail[i] <= (i == NLEV - 1) ? '0 : NIL;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_map <= i_cfg_wdata;
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: r_clr <= r_clr + NB_W'(1);
                S_IDLE: begin
                    r_kind   <= i_kind;
                    r_size   <= i_size;
                    r_offset <= i_offset;
                end
                S_DEC: begin
                    r_status <= d_big ? ST_BIG : ST_OK;
                    r_res    <= '0;
                    r_orig   <= d_lv;
                    r_b      <= d_lv;
                    r_node   <= node_of(d_kb, d_lv);
                end
                S_ALOOP: begin
                    r_second <= 1'b0;
                    r_gl     <= r_b;
                    r_gret   <= S_APOP;
                end
                S_APOP: begin
                    r_sl  <= r_b;
                    r_ret <= S_ACHK;
                end
                S_ACHK: begin
                    if (r_k[NB_W] && !r_second) begin
                        if (r_b != r_lim || r_b == '0) begin
                            if (r_b != '0) r_b <= r_b - LV_W'(1);
                        end else begin
                            r_second <= 1'b1;
                            r_gl     <= r_b - LV_W'(1);
                            r_gret   <= S_APOP;
                        end
                    end
                end
                S_ATOUCH: begin
                    r_off <= a_off;
                    if (!t_ok) begin
                        r_sl  <= r_b;
                        r_sk  <= r_k[NB_W-1:0];
                        r_ret <= S_FAIL;
                    end else begin
                        if (t_big) r_hwm <= HW_W'(tend);
                        r_node <= a_node;
                        r_fi   <= pidx(a_node);
                        r_ret  <= S_ASPL;
                    end
                end
                S_ASPL: begin
                    if (r_b < r_orig) begin
                        r_node <= spl_n;
                        r_b    <= r_b + LV_W'(1);
                        r_fi   <= pidx(spl_n);
                        r_ret  <= S_ASPL2;
                    end else begin
                        r_status <= ST_OK;
                        r_res    <= OFF_W'(r_off + AW'(HEADER_BYTES));
                    end
                end
                S_ASPL2: begin
                    r_sl  <= r_b;
                    r_sk  <= no_blk(r_node + ND_W'(1), r_b);
                    r_ret <= S_ASPL;
                end
                S_FLOOP: begin
                    r_fi  <= pidx(r_node);
                    r_ret <= S_FCHK;
                end
                S_FCHK: begin
                    r_sl  <= r_b;
                    r_sk  <= no_blk(bud_n, r_b);
                    r_ret <= S_FUP;
                end
                S_FUP: begin
                    r_node <= (r_node - ND_W'(1)) >> 1;
                    r_b    <= r_b - LV_W'(1);
                end
                S_FHEAD: begin
                    r_sl  <= r_b;
                    r_sk  <= no_blk(r_node, r_b);
                    r_ret <= S_FIN;
                end
                S_GBIT: begin
                    r_sl <= r_lim;
                    if (!sb_rd[0]) begin
                        r_sk  <= '0;
                        r_ret <= S_GA1;
                    end else if (t_ok) begin
                        if (t_big) r_hwm <= HW_W'(tend);
                        r_sk  <= rk;
                        r_ret <= S_GB1;
                    end
                end
                S_GA1: begin
                    r_lim <= r_lim - LV_W'(1);
                    r_head[r_lim - LV_W'(1)] <= NIL;
                    r_tail[r_lim - LV_W'(1)] <= NIL;
                    r_sl  <= r_lim - LV_W'(1);
                    r_sk  <= '0;
                    r_ret <= S_GTEST;
                end
                S_GB1: begin
                    r_lim <= r_lim - LV_W'(1);
                    r_head[r_lim - LV_W'(1)] <= NIL;
                    r_tail[r_lim - LV_W'(1)] <= NIL;
                    r_fi  <= pidx(rootp_n);
                    r_ret <= S_GTEST;
                end
                S_PT1: r_t <= tl;
                S_PT2: begin
                    if (r_t[NB_W]) r_head[r_sl] <= {1'b0, r_sk};
                    r_tail[r_sl] <= {1'b0, r_sk};
                end
                S_PH1: r_t <= hd;
                S_PH2: begin
                    if (r_t[NB_W]) r_tail[r_sl] <= {1'b0, r_sk};
                    r_head[r_sl] <= {1'b0, r_sk};
                end
                S_RM2: begin
                    if (lp_rd[NB_W]) r_head[r_sl] <= ln_rd;
                    if (ln_rd[NB_W]) r_tail[r_sl] <= lp_rd;
                end
                S_PP1: r_k <= tl;
                S_PP2: begin
                    r_tail[r_sl] <= lp_rd;
                    if (lp_rd[NB_W]) r_head[r_sl] <= NIL;
                end
                S_FL2: r_fbit <= ~sb_rd[0];
                S_FAIL: r_status <= ST_NOFREE;
                S_FIN: begin
                    if (out_free) begin
                        r_ostatus <= r_status;
                        r_ores    <= (r_status == ST_OK) ? r_res : '0;
                        r_ohw     <= r_hwm;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_result_offset = r_ores;
    assign o_high_water    = r_ohw;

endmodule

FILE: tb/buddy_allocator_top_tb.sv
// self-checking testbench for the buddy allocator: directed table, random mix, scoreboard
`timescale 1ns / 1ps

module buddy_allocator_top_tb;
    import bud_pkg::*;

    localparam int unsigned NBLK = 8192;
    localparam int unsigned NIL = 8192;
    localparam int unsigned NLEV = 14;
    localparam int unsigned HEAP = 65536;
    localparam int unsigned HDR = 4;
    localparam int unsigned LINKB = 8;
    localparam int unsigned WDOG_LIMIT = 30000;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  roff;
        logic [HW_W-1:0]   hw;
    } result_t;

    typedef struct {
        logic              kind;
        int unsigned       size;
        int unsigned       offset;
        bit                live_off;
        bit                typed;
        logic [STAT_W-1:0] status;
        int unsigned       roff;
        int unsigned       hw;
    } row_t;

    typedef struct {
        int unsigned offset;
        int unsigned size;
    } block_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = KIND_ALLOC;
    logic [SIZE_W-1:0] i_size = '0;
    logic [OFF_W-1:0] i_offset = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [OFF_W-1:0] o_result_offset;
    logic [HW_W-1:0] o_high_water;

    buddy_allocator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_size(i_size), .i_offset(i_offset),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_result_offset(o_result_offset),
        .o_high_water(o_high_water)
    );

    always #2 i_clk = ~i_clk;

    // allocator shadow state
    bit          split_q[NBLK];
    int unsigned nxt_q[NBLK];
    int unsigned prv_q[NBLK];
    int unsigned head_q[NLEV];
    int unsigned tail_q[NLEV];
    int unsigned root_lv;
    int unsigned hwm;
    int unsigned mapped;

    result_t expected_q[$];
    block_t  live_q[$];
    bit      failed = 0;
    bit      quiet = 0;
    int      hold_req = 0;
    bit      hold_done = 0;
    int      hold_cnt = 0;
    int      idle_cycles = 0;
    bit      in_take;

    function automatic void list_push_tail(int unsigned lv, int unsigned k);
        int unsigned t;
        t = tail_q[lv];
        k &= NBLK - 1;
        prv_q[k] = t;
        nxt_q[k] = NIL;
        if (t < NBLK) nxt_q[t] = k; else head_q[lv] = k;
        tail_q[lv] = k;
    endfunction

    function automatic void list_push_head(int unsigned lv, int unsigned k);
        int unsigned h;
        h = head_q[lv];
        k &= NBLK - 1;
        nxt_q[k] = h;
        prv_q[k] = NIL;
        if (h < NBLK) prv_q[h] = k; else tail_q[lv] = k;
        head_q[lv] = k;
    endfunction

    function automatic int unsigned list_pop_tail(int unsigned lv);
        int unsigned t, p;
        t = tail_q[lv];
        if (t >= NBLK) return NIL;
        p = prv_q[t];
        tail_q[lv] = p;
        if (p < NBLK) nxt_q[p] = NIL; else head_q[lv] = NIL;
        return t;
    endfunction

    function automatic void list_unlink(int unsigned lv, int unsigned k);
        int unsigned p, n;
        k &= NBLK - 1;
        p = prv_q[k];
        n = nxt_q[k];
        if (p < NBLK) nxt_q[p] = n; else head_q[lv] = n;
        if (n < NBLK) prv_q[n] = p; else tail_q[lv] = p;
    endfunction

    function automatic void toggle_parent(int unsigned node);
        int unsigned i;
        i = ((node - 1) / 2) & (NBLK - 1);
        split_q[i] = ~split_q[i];
    endfunction

    function automatic bit parent_split(int unsigned node);
        return split_q[((node - 1) / 2) & (NBLK - 1)];
    endfunction

    function automatic int unsigned node_to_off(int unsigned node, int unsigned lv);
        return ((node - (32'd1 << lv) + 1) << (16 - lv)) & (HEAP - 1);
    endfunction

    function automatic int unsigned off_to_node(int unsigned off, int unsigned lv);
        return (off >> (16 - lv)) + (32'd1 << lv) - 1;
    endfunction

    function automatic int unsigned level_of(int unsigned req);
        int unsigned lv, sz;
        lv = NLEV - 1;
        sz = 8;
        while (sz < req && lv > 0) begin
            lv--;
            sz <<= 1;
        end
        return lv;
    endfunction

    function automatic bit heap_touch(int unsigned end_off);
        if (end_off > hwm) begin
            if (end_off >= mapped) return 0;
            hwm = end_off;
        end
        return 1;
    endfunction

    function automatic bit grow_tree(int unsigned lv);
        int unsigned root, right;
        while (lv < root_lv) begin
            root = (32'd1 << root_lv) - 1;
            if (!parent_split(root)) begin
                list_unlink(root_lv, 0);
                root_lv--;
                head_q[root_lv] = NIL;
                tail_q[root_lv] = NIL;
                list_push_tail(root_lv, 0);
                continue;
            end
            right = node_to_off(root + 1, root_lv);
            if (!heap_touch(right + LINKB)) return 0;
            list_push_tail(root_lv, right >> 3);
            root_lv--;
            head_q[root_lv] = NIL;
            tail_q[root_lv] = NIL;
            root = (root - 1) / 2;
            if (root != 0) toggle_parent(root);
        end
        return 1;
    endfunction

    function automatic logic [STAT_W-1:0] alloc_block(int unsigned req, output int unsigned res);
        int orig, b;
        int unsigned k, off, need, node;
        orig = level_of(req);
        b = orig;
        res = 0;
        while (b >= 0) begin
            if (!grow_tree(b)) return ST_NOFREE;
            k = list_pop_tail(b);
            if (k >= NBLK) begin
                if (b != root_lv || b == 0) begin
                    b--;
                    continue;
                end
                if (!grow_tree(b - 1)) return ST_NOFREE;
                k = list_pop_tail(b);
                if (k >= NBLK) return ST_NOFREE;
            end
            off = k << 3;
            need = 32'd1 << (16 - b);
            if (b < orig) need = need / 2 + LINKB;
            if (!heap_touch(off + need)) begin
                list_push_tail(b, k);
                return ST_NOFREE;
            end
            node = off_to_node(off, b);
            if (node != 0) toggle_parent(node);
            while (b < orig) begin
                node = node * 2 + 1;
                b++;
                toggle_parent(node);
                list_push_tail(b, node_to_off(node + 1, b) >> 3);
            end
            res = off + HDR;
            return ST_OK;
        end
        return ST_NOFREE;
    endfunction

    function automatic void free_block(int unsigned req, int unsigned offset);
        int unsigned blk, lv, node;
        blk = (offset - HDR) & (HEAP - 1);
        lv = level_of(req);
        if (lv < root_lv) return;
        node = off_to_node(blk, lv);
        while (node != 0) begin
            toggle_parent(node);
            if (parent_split(node) || lv == root_lv) break;
            list_unlink(lv, node_to_off(((node - 1) ^ 1) + 1, lv) >> 3);
            node = (node - 1) / 2;
            lv--;
        end
        list_push_head(lv, node_to_off(node, lv) >> 3);
    endfunction

    function automatic result_t predict_word(logic kind, int unsigned size, int unsigned offset);
        result_t r;
        int unsigned req, res;
        req = size + HDR;
        res = 0;
        r.status = ST_OK;
        if (req > HEAP) r.status = ST_BIG;
        else if (kind == KIND_ALLOC) r.status = alloc_block(req, res);
        else free_block(req, offset);
        if (r.status != ST_OK) res = 0;
        r.roff = res[OFF_W-1:0];
        r.hw = hwm[HW_W-1:0];
        return r;
    endfunction

    task automatic send_word(logic kind, int unsigned size, int unsigned offset, output result_t r);
        bit acc;
        while (!quiet && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_size <= size[SIZE_W-1:0];
        i_offset <= offset[OFF_W-1:0];
        do begin
            @(negedge i_clk);
            acc = !o_in_stall;
            @(posedge i_clk);
        end while (!acc);
        r = predict_word(kind, size, offset);
        expected_q.push_back(r);
        if (kind == KIND_ALLOC && r.status == ST_OK) live_q.push_back('{r.roff, size});
    endtask

    task automatic write_mapped(int unsigned v);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mapped = v;
    endtask

    // receiver stall: random idling, long hold on request
    always @(posedge i_clk) begin
        if (hold_req != 0 && !hold_done) begin
            hold_cnt <= hold_req;
            hold_done <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 19);
        end
    end

    always @(negedge i_clk) begin
        in_take = i_in_valid && !o_in_stall;
        if (o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word");
                failed = 1;
            end else begin
                result_t e;
                e = expected_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    failed = 1;
                end
                if (o_result_offset !== e.roff) begin
                    $error("result_offset exp %0d got %0d", e.roff, o_result_offset);
                    failed = 1;
                end
                if (o_high_water !== e.hw) begin
                    $error("high_water exp %0d got %0d", e.hw, o_high_water);
                    failed = 1;
                end
            end
            idle_cycles = 0;
        end else if (in_take || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    row_t dir_tbl[16];
    int unsigned mapped_set[6] = '{65536, 0, 131071, 3000, 20000, 65536};

    initial begin
        result_t r;
        block_t b;
        int unsigned n, sz, off, sel;
        logic k;
        dir_tbl = '{
            '{KIND_ALLOC, 4,     0,     0, 1, ST_OK,  4, 8},
            '{KIND_FREE,  4,     0,     1, 1, ST_OK,  0, 8},
            '{KIND_ALLOC, 65535, 0,     0, 1, ST_BIG, 0, 8},
            '{KIND_FREE,  65535, 65535, 0, 1, ST_BIG, 0, 8},
            '{KIND_FREE,  40000, 0,     0, 1, ST_OK,  0, 8},
            '{KIND_FREE,  100,   2,     0, 1, ST_OK,  0, 8},
            '{KIND_ALLOC, 0,     0,     0, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 1,     0,     0, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 12,    0,     0, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 60,    0,     0, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 65532, 0,     0, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 1000,  0,     0, 0, ST_OK,  0, 0},
            '{KIND_FREE,  0,     0,     1, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 32764, 0,     0, 0, ST_OK,  0, 0},
            '{KIND_FREE,  0,     0,     1, 0, ST_OK,  0, 0},
            '{KIND_ALLOC, 28,    0,     0, 0, ST_OK,  0, 0}
        };
        for (int i = 0; i < NBLK; i++) split_q[i] = 0;
        for (int i = 0; i < NLEV; i++) begin
            head_q[i] = NIL;
            tail_q[i] = NIL;
        end
        root_lv = NLEV - 1;
        list_push_tail(NLEV - 1, 0);
        hwm = LINKB;
        mapped = 65536;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            sz = dir_tbl[i].size;
            off = dir_tbl[i].offset;
            if (dir_tbl[i].live_off && live_q.size() != 0) begin
                b = live_q.pop_back();
                off = b.offset;
                sz = b.size;
            end
            send_word(dir_tbl[i].kind, sz, off, r);
            if (dir_tbl[i].typed && (r.status != dir_tbl[i].status
                    || r.roff != dir_tbl[i].roff || r.hw != dir_tbl[i].hw)) begin
                $error("table row %0d disagrees with typed result", i);
                failed = 1;
            end
        end

        foreach (mapped_set[p]) begin
            write_mapped(mapped_set[p]);
            if (p == 1) hold_req = 3000;
            quiet = (p == 3);
            n = 0;
            while (n < 180) begin
                sel = $urandom_range(99);
                if (sel < 5) begin
                    k = KIND_FREE;
                    sz = $urandom_range(65535, 65533);
                    off = $urandom;
                end else if (sel < 12) begin
                    k = KIND_ALLOC;
                    sz = (sel < 8) ? $urandom_range(65535, 65533) : $urandom_range(65535);
                    n++;
                end else if (live_q.size() != 0 && sel < 50) begin
                    k = KIND_FREE;
                    sel = $urandom_range(live_q.size() - 1);
                    b = live_q[sel];
                    live_q.delete(sel);
                    sz = b.size;
                    off = b.offset;
                    n++;
                end else begin
                    k = KIND_ALLOC;
                    sz = ($urandom_range(99) < 70) ? $urandom_range(60) : $urandom_range(2000);
                    off = $urandom;
                    n++;
                end
                send_word(k, sz, off, r);
            end
            quiet = 0;
        end

        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bud_pkg.sv
rtl/core/bud_ram.sv
rtl/core/buddy_allocator_top.sv
tb/buddy_allocator_top_tb.sv
